// ===== sv/ssf_pkg.sv =====
// shared types and constants for the scrolling starfield pixel generator
// no dependencies; imported by every module of the block
package ssf_pkg;

   // request command codes
   typedef enum logic [2:0] {
      CMD_ROM_LOAD = 3'd0,
      CMD_HSCROLL  = 3'd1,
      CMD_VSCROLL  = 3'd2,
      CMD_CONTROL  = 3'd3,
      CMD_PIXEL    = 3'd4
   } cmd_type;

   localparam int unsigned ROM_ADDR_W = 12;
   localparam int unsigned ROM_DATA_W = 8;
   localparam int unsigned COLOR_W    = 10;

   // color base 0x378; the latch bits 7..5 fill the three low bits
   localparam logic [6:0] COLOR_BASE_HI = 7'h6f;

   // visible window limits
   localparam logic [8:0] WIN_X_MIN  = 9'd64;
   localparam logic [8:0] WIN_X_MAX  = 9'd447;
   localparam logic [7:0] WIN_Y_MIN  = 8'd16;
   localparam logic [7:0] WIN_Y_MAX  = 8'd239;
   localparam logic [8:0] LINE_START = 9'd64;

   // scroll and enable state seen by the pixel path
   typedef struct packed {
      logic [8:0] hscroll;
      logic [7:0] vscroll;
      logic       carry;
      logic       enable;
   } scroll_state_type;

   // decoded pixel handed from the front stage to the color stage
   typedef struct packed {
      logic       win;
      logic       draw;     // enabled, in window and both rejection tests passed
      logic       fetch;    // latch takes the rom byte read for this pixel
      logic [4:0] hsum_lo;
   } pix_info_type;

endpackage

// ===== sv/ssf_scroll_regs.sv =====
// scroll counters, carry flop and starfield enable
// depends on ssf_pkg
module ssf_scroll_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [2:0]                cmd,
   input  logic                      star_on,
   output ssf_pkg::scroll_state_type state
);
   import ssf_pkg::*;

   scroll_state_type state_ff;
   scroll_state_type state_in;

   // next state per command
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (cmd)
            CMD_HSCROLL: begin
               state_in.hscroll = state_ff.hscroll + 9'd1;
               // bit 8 rises only when the low byte wraps from all ones
               if (state_ff.hscroll == 9'h0ff) begin
                  state_in.carry = ~state_ff.carry;
               end
            end
            CMD_VSCROLL: begin
               state_in.vscroll = state_ff.vscroll + 8'd1;
            end
            CMD_CONTROL: begin
               if (star_on != state_ff.enable) begin
                  state_in.enable  = star_on;
                  state_in.carry   = 1'b1;
                  state_in.hscroll = '0;
                  state_in.vscroll = '0;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hscroll <= '0;
         state_ff.vscroll <= '0;
         state_ff.carry   <= 1'b1;
         state_ff.enable  <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== sv/ssf_star_rom.sv =====
// 4096 x 8 star rom, one write port and one registered read port
// depends on ssf_pkg
module ssf_star_rom (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ssf_pkg::ROM_ADDR_W-1:0] wr_addr,
   input  logic [ssf_pkg::ROM_DATA_W-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [ssf_pkg::ROM_ADDR_W-1:0] rd_addr,
   output logic [ssf_pkg::ROM_DATA_W-1:0] rd_data
);
   import ssf_pkg::*;

   logic [ROM_DATA_W-1:0] rom_mem_ff [2**ROM_ADDR_W];
   logic [ROM_DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rom_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ssf_pixel_front.sv =====
// pixel front stage: scroll sums, window, rejection tests, rom address
// depends on ssf_pkg
module ssf_pixel_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           is_pixel,
   input  logic                           out_free,
   input  logic [8:0]                     pixel_x,
   input  logic [7:0]                     pixel_y,
   input  ssf_pkg::scroll_state_type      state,
   output logic [ssf_pkg::ROM_ADDR_W-1:0] rom_addr,
   output logic                           pix_valid,
   output ssf_pkg::pix_info_type          pix_info
);
   import ssf_pkg::*;

   logic [7:0]   hc;
   logic [8:0]   hsum;
   logic [7:0]   vsum;
   logic         win;
   logic         line_start;
   logic         tests_ok;
   logic [4:0]   before_lo;
   logic         active;
   pix_info_type info;

   logic         pix_valid_ff;
   pix_info_type pix_info_ff;
   logic [4:0]   prev_hsum_ff;
   logic [4:0]   prev_hsum_in;

   // scrolled position
   assign hc   = state.hscroll[7:0];
   assign hsum = {1'b0, hc} + {1'b0, pixel_x[7:0]};
   assign vsum = state.vscroll + pixel_y;

   assign win = (pixel_x >= WIN_X_MIN) && (pixel_x <= WIN_X_MAX) &&
                (pixel_y >= WIN_Y_MIN) && (pixel_y <= WIN_Y_MAX);
   assign line_start = (pixel_x == LINE_START);
   assign active     = win && state.enable;

   // rejection tests on line parity and column
   assign tests_ok = (vsum[2] ^ pixel_x[5]) && !(vsum[1] || hsum[2]);

   // at line start the previous sum is forced to hscroll + 63
   assign before_lo = line_start ? (hc[4:0] + 5'd31) : prev_hsum_ff;

   // preload and reload share one address: only h[8:5] reach the rom
   assign rom_addr = {vsum, state.carry ^ hsum[8], hsum[7:5]};

   always_comb begin
      info.win     = win;
      info.draw    = active && tests_ok;
      info.fetch   = active && (line_start || (tests_ok && (before_lo == 5'h1f)));
      info.hsum_lo = hsum[4:0];
   end

   assign prev_hsum_in = (accept && is_pixel) ? hsum[4:0] : prev_hsum_ff;

   // the held pixel leaves once the color stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         prev_hsum_ff <= '0;
      end else begin
         prev_hsum_ff <= prev_hsum_in;
         if (accept) begin
            pix_valid_ff <= is_pixel;
         end else if (out_free) begin
            pix_valid_ff <= 1'b0;
         end
      end
   end

   // pixel payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_info_ff <= info;
      end
   end

   assign pix_valid = pix_valid_ff;
   assign pix_info  = pix_info_ff;

endmodule

// ===== sv/ssf_color_stage.sv =====
// rom latch update, lit test and the response register
// depends on ssf_pkg
module ssf_color_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pix_valid,
   input  ssf_pkg::pix_info_type          pix_info,
   input  logic [ssf_pkg::ROM_DATA_W-1:0] rom_data,
   input  logic                           rsp_stall,
   output logic                           out_free,
   output logic                           rsp_valid,
   output logic                           rsp_in_window,
   output logic                           rsp_star_lit,
   output logic [ssf_pkg::COLOR_W-1:0]    rsp_color_index
);
   import ssf_pkg::*;

   logic [ROM_DATA_W-1:0] latch_ff;
   logic [ROM_DATA_W-1:0] latch_in;
   logic                  lit;
   logic                  load;
   logic                  rsp_valid_ff;
   logic                  in_window_ff;
   logic                  star_lit_ff;
   logic [COLOR_W-1:0]    color_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = pix_valid && out_free;

   // latch reload, then compare against the scrolled column
   assign latch_in = pix_info.fetch ? rom_data : latch_ff;
   assign lit      = pix_info.draw &&
                     ((latch_in[4:0] ^ pix_info.hsum_lo ^ 5'd1) == 5'h1f);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         latch_ff     <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= pix_valid;
         end
         if (load) begin
            latch_ff <= latch_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load) begin
         in_window_ff <= pix_info.win;
         star_lit_ff  <= lit;
         color_ff     <= lit ? {COLOR_BASE_HI, latch_in[7:5]} : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_window   = in_window_ff;
   assign rsp_star_lit    = star_lit_ff;
   assign rsp_color_index = color_ff;

endmodule

// ===== sv/scrolling_starfield_pixel_generator_unit.sv =====
// top level of the scrolling starfield pixel generator
// depends on ssf_pkg, ssf_scroll_regs, ssf_star_rom, ssf_pixel_front, ssf_color_stage

// Takes one request per clock while req_stall is low: rom loads, scroll ticks,
// control writes and raster pixels, with pixels in raster order. Every pixel
// request gives one response; the pixel is held in the front-stage register and
// then loaded into the response register once the color stage is free. Other
// commands give none. The rate is one request per cycle while unstalled, set by
// the single read port of the 4096 x 8 star rom, which is read once for each
// accepted request. The rom has no reset and must be loaded before pixels that
// reach its entries. req_stall rises only while a pixel waits behind a stalled
// response.
module scrolling_starfield_pixel_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [11:0] req_rom_address,
   input  logic [7:0]  req_rom_byte,
   input  logic        req_star_on,
   input  logic [8:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_in_window,
   output logic        rsp_star_lit,
   output logic [9:0]  rsp_color_index
);
   import ssf_pkg::*;

   logic                  accept;
   logic                  is_pixel;
   scroll_state_type      state;
   logic [ROM_ADDR_W-1:0] rom_addr;
   logic [ROM_DATA_W-1:0] rom_data;
   logic                  pix_valid;
   pix_info_type          pix_info;
   logic                  out_free;

   // handshake
   assign req_stall = pix_valid && !out_free;
   assign accept    = req_valid && !req_stall;
   assign is_pixel  = (req_cmd == CMD_PIXEL);

   ssf_scroll_regs u_scroll (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_cmd),
      .star_on (req_star_on),
      .state   (state)
   );

   ssf_star_rom u_rom (
      .clock   (clock),
      .wr_en   (accept && (req_cmd == CMD_ROM_LOAD)),
      .wr_addr (req_rom_address),
      .wr_data (req_rom_byte),
      .rd_en   (accept),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   ssf_pixel_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .is_pixel  (is_pixel),
      .out_free  (out_free),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .state     (state),
      .rom_addr  (rom_addr),
      .pix_valid (pix_valid),
      .pix_info  (pix_info)
   );

   ssf_color_stage u_color (
      .clock           (clock),
      .reset           (reset),
      .pix_valid       (pix_valid),
      .pix_info        (pix_info),
      .rom_data        (rom_data),
      .rsp_stall       (rsp_stall),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_in_window   (rsp_in_window),
      .rsp_star_lit    (rsp_star_lit),
      .rsp_color_index (rsp_color_index)
   );

   // stall only with a pixel waiting in the front stage
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> pix_valid)
      else $error("request stalled with no pixel in flight");

   // an accepted pixel always lands in the front stage
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_pixel) |=> pix_valid)
      else $error("accepted pixel lost");

   // a lit star lies inside the window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_star_lit || rsp_in_window))
      else $error("star lit outside the window");

   // color is nonzero exactly when lit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_color_index != '0) == rsp_star_lit))
      else $error("color does not match lit flag");

endmodule

// ===== dv/scrolling_starfield_pixel_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for scrolling_starfield_pixel_generator_unit
// depends on ssf_pkg and the block itself; drives a directed table, then random rasters

module scrolling_starfield_pixel_generator_unit_tb;
   import ssf_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 750;
   localparam int unsigned PRINT_LIMIT  = 100;
   localparam int unsigned HOLD_AFTER   = 120;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned ROW_ENTRIES  = 16;

   // command codes the block ignores
   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam logic [9:0] STAR_COLOR_BASE = 10'h378;

   typedef struct packed {
      logic       win;
      logic       lit;
      logic [9:0] color;
   } pixel_result_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [11:0]      addr;
      logic [7:0]       data;
      logic             on;
      logic [8:0]       x;
      logic [7:0]       y;
      logic             known;
      pixel_result_type res;
   } directed_row_type;

   // directed table; known rows carry a result read straight off the coordinates
   localparam directed_row_type DIRECTED [25] = '{
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd0,   8'd0,   1'b1, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'hfff, 8'hff, 1'b1, 9'd511, 8'd255, 1'b1, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd64,  8'd16,  1'b1, '{1'b1, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd447, 8'd239, 1'b1, '{1'b1, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd63,  8'd16,  1'b1, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd448, 8'd239, 1'b1, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd200, 8'd15,  1'b1, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd200, 8'd240, 1'b1, '{1'b0, 1'b0, 10'h000}},
      '{CMD_SPARE_5,  12'hfff, 8'hff, 1'b1, 9'd511, 8'd255, 1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_SPARE_6,  12'h000, 8'h00, 1'b0, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_SPARE_7,  12'ha5a, 8'h5a, 1'b1, 9'h0aa, 8'h55,  1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_CONTROL,  12'h000, 8'h00, 1'b0, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_ROM_LOAD, 12'h000, 8'hff, 1'b0, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_ROM_LOAD, 12'hfff, 8'h00, 1'b0, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_CONTROL,  12'h000, 8'h00, 1'b1, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_CONTROL,  12'h000, 8'h00, 1'b1, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_HSCROLL,  12'h000, 8'h00, 1'b0, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_VSCROLL,  12'h000, 8'h00, 1'b0, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd64,  8'd16,  1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd65,  8'd16,  1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd66,  8'd16,  1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd100, 8'd16,  1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd447, 8'd239, 1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_CONTROL,  12'h000, 8'h00, 1'b0, 9'd0,   8'd0,   1'b0, '{1'b0, 1'b0, 10'h000}},
      '{CMD_PIXEL,    12'h000, 8'h00, 1'b0, 9'd100, 8'd100, 1'b1, '{1'b1, 1'b0, 10'h000}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_ROM_LOAD;
   logic [11:0] req_rom_address = '0;
   logic [7:0]  req_rom_byte = '0;
   logic        req_star_on = 1'b0;
   logic [8:0]  req_pixel_x = '0;
   logic [7:0]  req_pixel_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_in_window;
   logic        rsp_star_lit;
   logic [9:0]  rsp_color_index;

   // known result that travels alongside a directed request
   logic             known_valid = 1'b0;
   pixel_result_type known_result = '0;

   // starfield state as the predictor sees it
   logic [7:0] star_bytes [4096];
   logic [8:0] h_count = '0;
   logic [7:0] v_count = '0;
   logic       carry_bit = 1'b1;
   logic       stars_enabled = 1'b0;
   logic [7:0] byte_latch = '0;
   logic [8:0] last_hsum = '0;

   pixel_result_type pixel_expect_q [$];

   // generator-side view, kept in request order so rom rows can be loaded ahead of use
   logic [7:0] gen_v = '0;
   logic       gen_on = 1'b0;
   bit         row_ready [256];
   int unsigned counted_items = 0;

   int unsigned error_count = 0;
   int unsigned responses_seen = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   bit          quiet = 1'b0;

   scrolling_starfield_pixel_generator_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_rom_address (req_rom_address),
      .req_rom_byte    (req_rom_byte),
      .req_star_on     (req_star_on),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_in_window   (rsp_in_window),
      .rsp_star_lit    (rsp_star_lit),
      .rsp_color_index (rsp_color_index)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // rom row {vsum, carry ^ h[8], h[7:5]}
   function automatic logic [7:0] star_byte_at(input logic [7:0] vsum, input logic [8:0] h);
      return star_bytes[{vsum, carry_bit ^ h[8], h[7:5]}];
   endfunction

   // advance the starfield state by one request; pixels produce a result
   task automatic apply_request(input logic [2:0] cmd, input logic [11:0] addr,
                                input logic [7:0] data, input logic on,
                                input logic [8:0] x, input logic [7:0] y,
                                output bit has_pixel, output pixel_result_type res);
      logic [8:0] old_h;
      logic [8:0] hsum;
      logic [8:0] prior_hsum;
      logic [7:0] vsum;
      logic [7:0] hc;
      has_pixel = 1'b0;
      res = '0;
      case (cmd)
         CMD_ROM_LOAD: star_bytes[addr] = data;
         CMD_HSCROLL: begin
            old_h = h_count;
            h_count = h_count + 9'd1;
            // carry flips when bit 8 rises
            if (h_count[8] && !old_h[8]) carry_bit = ~carry_bit;
         end
         CMD_VSCROLL: v_count = v_count + 8'd1;
         CMD_CONTROL: begin
            if (on != stars_enabled) begin
               stars_enabled = on;
               carry_bit = 1'b1;
               h_count = '0;
               v_count = '0;
            end
         end
         CMD_PIXEL: begin
            hc = h_count[7:0];
            hsum = {1'b0, hc} + {1'b0, x[7:0]};
            vsum = v_count + y;
            res.win = x >= WIN_X_MIN && x <= WIN_X_MAX && y >= WIN_Y_MIN && y <= WIN_Y_MAX;
            if (res.win && stars_enabled) begin
               // line start preloads the latch
               if (x == LINE_START) begin
                  byte_latch = star_byte_at(vsum, ({1'b0, hc} + 9'd64) & 9'h1e0);
                  last_hsum = {1'b0, hc} + 9'd63;
               end
               prior_hsum = last_hsum;
               // the two rejection tests, then reload on a 5-bit rollover
               if ((vsum[2] ^ x[5]) && !vsum[1] && !hsum[2]) begin
                  if (prior_hsum[4:0] == 5'h1f) byte_latch = star_byte_at(vsum, hsum);
                  if ((byte_latch[4:0] ^ hsum[4:0] ^ 5'd1) == 5'h1f) begin
                     res.lit = 1'b1;
                     res.color = STAR_COLOR_BASE | {7'd0, byte_latch[7:5]};
                  end
               end
            end
            last_hsum = hsum;
            has_pixel = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [9:0] got,
                                  input logic [9:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch %s at response %0d: got %h expected %h", what,
                  responses_seen, got, want);
   endtask

   // predict every accepted request
   always @(posedge clock) begin : track_requests
      bit               has_pixel;
      pixel_result_type res;
      if (!reset && req_valid && !req_stall) begin
         apply_request(req_cmd, req_rom_address, req_rom_byte, req_star_on,
                       req_pixel_x, req_pixel_y, has_pixel, res);
         if (has_pixel) pixel_expect_q.push_back(known_valid ? known_result : res);
      end
   end

   // compare every accepted response with the oldest expectation
   always @(posedge clock) begin : check_responses
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_expect_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_color_index, '0);
         end else begin
            want = pixel_expect_q.pop_front();
            if (rsp_in_window !== want.win)
               report_mismatch("in_window", {9'd0, rsp_in_window}, {9'd0, want.win});
            if (rsp_star_lit !== want.lit)
               report_mismatch("star_lit", {9'd0, rsp_star_lit}, {9'd0, want.lit});
            if (rsp_color_index !== want.color)
               report_mismatch("color_index", rsp_color_index, want.color);
         end
         responses_seen <= responses_seen + 1;
      end
   end

   // receiver: random stalls, one long hold-off, none during the quiet stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && responses_seen >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 19);
      end
   end

   // offer one request, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_request(input logic [2:0] cmd, input logic [11:0] addr,
                               input logic [7:0] data, input logic on,
                               input logic [8:0] x, input logic [7:0] y,
                               input logic known, input pixel_result_type known_res);
      while (!quiet && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_rom_address <= addr;
      req_rom_byte    <= data;
      req_star_on     <= on;
      req_pixel_x     <= x;
      req_pixel_y     <= y;
      known_valid     <= known;
      known_result    <= known_res;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // issue a request; an enabled in-window pixel first gets its rom row loaded
   task automatic issue_request(input logic [2:0] cmd, input logic [11:0] addr,
                                input logic [7:0] data, input logic on,
                                input logic [8:0] x, input logic [7:0] y,
                                input logic known, input pixel_result_type known_res);
      logic [7:0] row;
      int         k;
      row = gen_v + y;
      if (cmd == CMD_PIXEL && gen_on && x >= WIN_X_MIN && x <= WIN_X_MAX &&
          y >= WIN_Y_MIN && y <= WIN_Y_MAX && !row_ready[row]) begin
         for (k = 0; k < ROW_ENTRIES; k++)
            send_request(CMD_ROM_LOAD, {row, 4'(k)}, 8'($urandom), 1'($urandom),
                         9'($urandom), 8'($urandom), 1'b0, '0);
         row_ready[row] = 1'b1;
         counted_items += ROW_ENTRIES;
      end
      send_request(cmd, addr, data, on, x, y, known, known_res);
      case (cmd)
         CMD_VSCROLL: gen_v = gen_v + 8'd1;
         CMD_CONTROL: begin
            if (on != gen_on) begin
               gen_on = on;
               gen_v = '0;
            end
         end
         default: ;
      endcase
      if (cmd <= CMD_PIXEL) counted_items++;
   endtask

   task automatic issue_plain(input logic [2:0] cmd, input logic on,
                              input logic [8:0] x, input logic [7:0] y);
      issue_request(cmd, 12'($urandom), 8'($urandom), on, x, y, 1'b0, '0);
   endtask

   // stimulus
   initial begin : stimulus
      int unsigned base;
      int unsigned progress;
      int          xi;
      int          len;
      int          n;
      int          seg;
      logic [7:0]  y;
      bit          burst_done;
      burst_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i])
         issue_request(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].data, DIRECTED[i].on,
                       DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].known, DIRECTED[i].res);

      // random rasters with scroll, control and load traffic in between
      base = counted_items;
      progress = 0;
      while (progress < RANDOM_ITEMS) begin
         quiet = progress >= 400 && progress < 550;
         if (!burst_done && progress >= 150) begin
            // long scroll run so the horizontal counter crosses bit 8
            burst_done = 1'b1;
            repeat (256 + $urandom_range(0, 40))
               issue_plain(CMD_HSCROLL, 1'($urandom), 9'($urandom), 8'($urandom));
         end
         seg = $urandom_range(99);
         if (seg < 60) begin
            // scanline in raster order
            y = ($urandom_range(9) == 0) ? 8'($urandom)
                                         : 8'($urandom_range(WIN_Y_MIN, WIN_Y_MAX));
            if ($urandom_range(3) != 0 && ((gen_v + y) & 8'd2) != 0) y = y ^ 8'd2;
            xi = ($urandom_range(9) < 7) ? 64 - int'($urandom_range(0, 8))
                                         : int'($urandom_range(0, 447));
            len = ($urandom_range(24) == 0) ? 450 - xi : int'($urandom_range(8, 48));
            for (n = 0; n < len && xi + n <= 511; n++)
               issue_plain(CMD_PIXEL, 1'($urandom), 9'(xi + n), y);
         end else if (seg < 75) begin
            repeat ($urandom_range(1, 4))
               issue_plain(CMD_HSCROLL, 1'($urandom), 9'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 2))
               issue_plain(CMD_VSCROLL, 1'($urandom), 9'($urandom), 8'($urandom));
         end else if (seg < 85) begin
            // stray pixels out of raster order
            repeat ($urandom_range(1, 6))
               issue_plain(CMD_PIXEL, 1'($urandom), 9'($urandom), 8'($urandom));
         end else if (seg < 90) begin
            issue_plain(CMD_CONTROL, $urandom_range(4) != 0, 9'($urandom), 8'($urandom));
         end else if (seg < 95) begin
            repeat ($urandom_range(1, 3))
               issue_plain(CMD_ROM_LOAD, 1'($urandom), 9'($urandom), 8'($urandom));
         end else begin
            issue_plain(3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)), 1'($urandom),
                        9'($urandom), 8'($urandom));
         end
         progress = counted_items - base;
      end
      quiet = 1'b0;

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
